// File: src/assert_macros.svh
// Assertion macros shared by the list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a condition at every clock edge outside reset.
`define ILE_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that a trigger is followed by a consequence in the next cycle.
`define ILE_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);
`else
`define ILE_ASSERT(lbl, cond, msg)
`define ILE_ASSERT_NEXT(lbl, trig, cons, msg)
`endif
`endif

// File: src/ile_pkg.sv
// Operation codes, status codes and fixed widths of the list engine.
package ile_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int CNT_W  = 6;

    typedef enum logic [2:0] {
        F_INS_FRONT = 3'd0,
        F_INS_REAR  = 3'd1,
        F_INS_AT    = 3'd2,
        F_DEL_FRONT = 3'd3,
        F_DEL_REAR  = 3'd4,
        F_DEL_AT    = 3'd5,
        F_DUMP      = 3'd6,
        F_DUMP_REV  = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

endpackage

// File: src/ile_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ile_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/indexed_list_engine_top.sv
// Top level of the indexed list engine: control sequencer around one entry RAM.
//
// The engine keeps an ordered list of up to CAPACITY signed 32-bit values packed
// in one RAM in list order, and takes one item at a time. Each item names an
// operation; every operation gives one result with last set, except a dump of a
// non-empty list, which gives one result per entry and sets last on the final one.
// A rejected operation goes straight to its result. An insert at position k
// walks the tail upward, one entry per cycle, and a delete at position k walks
// the tail downward. A dump streams one entry per cycle while the output does
// not stall. The walks are bound by the one RAM read port and the one write
// port; an insert at the front of a list one entry short of full or a delete
// from the front of a full list is the worst case. The input stalls while an
// item is in work; the result register lets the next item start while a
// result still waits.
`include "assert_macros.svh"

module indexed_list_engine_top
    import ile_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [2:0]               func,
    input  logic signed [DATA_W-1:0] value_in,
    input  logic [POS_W-1:0]         position,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] value_out,
    output logic                     last,
    output logic [CNT_W-1:0]         count
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UP   = 5'b00010,
        S_DN   = 5'b00100,
        S_DUMP = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       cur_reg, cur_next;
    logic [CW-1:0]       tgt_reg, tgt_next;
    logic [CW-1:0]       dleft_reg, dleft_next;
    logic [AW-1:0]       dptr_reg, dptr_next;
    logic [AW-1:0]       pend_addr_reg, pend_addr_next;
    logic                pend_reg, pend_next;
    logic                cap_reg, cap_next;
    logic                fwd_reg, fwd_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [DATA_W-1:0]   res_reg, res_next;
    status_t             st_reg, st_next;

    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic [DATA_W-1:0]   value_out_reg, value_out_next;
    logic                last_reg, last_next;
    logic [CNT_W-1:0]    count_out_reg, count_out_next;

    logic                ram_wr_en, ram_rd_en;
    logic [AW-1:0]       ram_wr_addr, ram_rd_addr;
    logic [DATA_W-1:0]   ram_wr_data, ram_rd_data;

    logic                in_accept, out_free;
    logic [CMPW-1:0]     count_ext, pos_ext, at_ext, cnt_snap;
    logic [CW-1:0]       cur_m1, count_m1, del_pos;
    func_t               op;

    ile_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign op        = func_t'(func);
    assign count_ext = CMPW'(count_reg);
    assign pos_ext   = CMPW'(position);
    assign cur_m1    = cur_reg - CW'(1);
    assign count_m1  = count_reg - CW'(1);

    // Insert target and delete target for the accepted item.
    always_comb
    begin
        case (op)
            F_INS_FRONT: at_ext = '0;
            F_INS_REAR:  at_ext = count_ext;
            default:     at_ext = pos_ext;
        endcase
        case (op)
            F_DEL_FRONT: del_pos = '0;
            F_DEL_REAR:  del_pos = count_m1;
            default:     del_pos = CW'(pos_ext);
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        tgt_next       = tgt_reg;
        dleft_next     = dleft_reg;
        dptr_next      = dptr_reg;
        pend_addr_next = pend_addr_reg;
        pend_next      = pend_reg;
        cap_next       = cap_reg;
        fwd_next       = fwd_reg;
        val_next       = val_reg;
        res_next       = res_reg;
        st_next        = st_reg;

        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        value_out_next = value_out_reg;
        last_next      = last_reg;
        count_out_next = count_out_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = pend_addr_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = cur_reg[AW-1:0];

        cnt_snap = count_ext;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    res_next  = '0;
                    st_next   = ST_OK;
                    pend_next = 1'b0;
                    cap_next  = 1'b0;
                    case (op) inside
                        F_INS_FRONT, F_INS_REAR, F_INS_AT:
                        begin
                            if (at_ext > count_ext)
                            begin
                                st_next    = ST_BADPOS;
                                state_next = S_OUT;
                            end
                            else if (count_reg == CW'(CAPACITY))
                            begin
                                st_next    = ST_FULL;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                cur_next   = count_reg;
                                tgt_next   = CW'(at_ext);
                                val_next   = value_in;
                                state_next = S_UP;
                            end
                        end
                        F_DEL_FRONT, F_DEL_REAR, F_DEL_AT:
                        begin
                            if (op == F_DEL_AT && pos_ext >= count_ext)
                            begin
                                st_next    = ST_BADPOS;
                                state_next = S_OUT;
                            end
                            else if (count_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                // Fetch the removed entry, then pull the tail down.
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = del_pos[AW-1:0];
                                cap_next    = 1'b1;
                                cur_next    = del_pos + CW'(1);
                                state_next  = S_DN;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                fwd_next    = (op == F_DUMP);
                                dptr_next   = (op == F_DUMP) ? '0 : count_m1[AW-1:0];
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = (op == F_DUMP) ? '0 : count_m1[AW-1:0];
                                dleft_next  = count_m1;
                                state_next  = S_DUMP;
                            end
                        end
                    endcase
                end
            end

            S_UP:
            begin
                // Write back the entry read last cycle one slot higher.
                if (pend_reg)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = pend_addr_reg;
                    ram_wr_data = ram_rd_data;
                end
                if (cur_reg > tgt_reg)
                begin
                    ram_rd_en      = 1'b1;
                    ram_rd_addr    = cur_m1[AW-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = cur_reg[AW-1:0];
                    cur_next       = cur_m1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = tgt_reg[AW-1:0];
                        ram_wr_data = val_reg;
                        count_next  = count_reg + CW'(1);
                        state_next  = S_OUT;
                    end
                end
            end

            S_DN:
            begin
                if (cap_reg)
                begin
                    res_next = ram_rd_data;
                end
                // Write back the entry read last cycle one slot lower.
                if (pend_reg)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = pend_addr_reg;
                    ram_wr_data = ram_rd_data;
                end
                cap_next = 1'b0;
                if (cur_reg < count_reg)
                begin
                    ram_rd_en      = 1'b1;
                    ram_rd_addr    = cur_reg[AW-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = cur_m1[AW-1:0];
                    cur_next       = cur_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg && !cap_reg)
                    begin
                        count_next = count_m1;
                        state_next = S_OUT;
                    end
                end
            end

            S_DUMP:
            begin
                // Read data holds until the next read, so a stalled result just waits.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    value_out_next = ram_rd_data;
                    last_next      = (dleft_reg == '0);
                    count_out_next = cnt_snap[CNT_W-1:0];
                    if (dleft_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        dptr_next   = fwd_reg ? dptr_reg + AW'(1) : dptr_reg - AW'(1);
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = fwd_reg ? dptr_reg + AW'(1) : dptr_reg - AW'(1);
                        dleft_next  = dleft_reg - CW'(1);
                    end
                end
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st_reg;
                    value_out_next = res_reg;
                    last_next      = 1'b1;
                    count_out_next = cnt_snap[CNT_W-1:0];
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            cap_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        tgt_reg       <= tgt_next;
        dleft_reg     <= dleft_next;
        dptr_reg      <= dptr_next;
        pend_addr_reg <= pend_addr_next;
        fwd_reg       <= fwd_next;
        val_reg       <= val_next;
        res_reg       <= res_next;
        st_reg        <= st_next;
        status_reg    <= status_next;
        value_out_reg <= value_out_next;
        last_reg      <= last_next;
        count_out_reg <= count_out_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value_out = value_out_reg;
    assign last      = last_reg;
    assign count     = count_out_reg;

    `ILE_ASSERT(a_count_cap, count_reg <= CW'(CAPACITY), "count above capacity")
    `ILE_ASSERT(a_no_rw_clash, !(ram_wr_en && ram_rd_en && ram_wr_addr == ram_rd_addr), "RAM clash")
    `ILE_ASSERT_NEXT(a_accept_busy, in_accept, state_reg != S_IDLE, "item started no work")
    `ILE_ASSERT_NEXT(a_last_idle, out_free && (state_reg == S_OUT), state_reg == S_IDLE && out_valid_reg && last_reg, "no final result")

endmodule

// File: tb/sv/indexed_list_engine_top_tb.sv
// Testbench of the indexed list engine: directed and random list operations, checked result by result.
`timescale 1ns / 1ps

module indexed_list_engine_top_tb
    import ile_pkg::*;
();

    localparam int CAP = 32;
    localparam int WATCHDOG_LIMIT = 20000;

    // One expected result of the engine.
    typedef struct packed {
        status_t                  st;
        logic signed [DATA_W-1:0] val;
        logic                     lst;
        logic [CNT_W-1:0]         cnt;
    } list_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [2:0]               func = '0;
    logic signed [DATA_W-1:0] value_in = '0;
    logic [POS_W-1:0]         position = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] value_out;
    logic                     last;
    logic [CNT_W-1:0]         count;

    // Shadow copy of the list held by the engine.
    logic signed [DATA_W-1:0] shadow_list [$];
    list_result_t             pending_results [$];
    int                       error_count = 0;
    int                       idle_cycles = 0;
    bit                       out_taken = 1'b0;
    int                       wait_left = 0;

    indexed_list_engine_top #(.CAPACITY(CAP)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .value_in(value_in), .position(position),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .value_out(value_out), .last(last), .count(count)
    );

    always #2 clk = ~clk;

    // Apply one operation to the shadow list and queue the results it causes.
    function automatic void predict_list_op(func_t f, logic signed [DATA_W-1:0] v,
                                            logic [POS_W-1:0] p);
        list_result_t r;
        int           n;
        int           at;
        n = shadow_list.size();
        r.st = ST_OK;
        r.val = '0;
        r.lst = 1'b1;
        case (f)
            F_INS_FRONT, F_INS_REAR, F_INS_AT:
            begin
                at = (f == F_INS_FRONT) ? 0 : (f == F_INS_REAR) ? n : int'(p);
                if (at > n)
                    r.st = ST_BADPOS;
                else if (n >= CAP)
                    r.st = ST_FULL;
                else
                    shadow_list.insert(at, v);
            end
            F_DEL_FRONT, F_DEL_REAR:
            begin
                if (n == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    at = (f == F_DEL_FRONT) ? 0 : n - 1;
                    r.val = shadow_list[at];
                    shadow_list.delete(at);
                end
            end
            F_DEL_AT:
            begin
                if (int'(p) >= n)
                    r.st = ST_BADPOS;
                else
                begin
                    r.val = shadow_list[p];
                    shadow_list.delete(int'(p));
                end
            end
            default:
            begin
                if (n == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    // Emit every entry; last goes on the final one only.
                    for (int i = 0; i < n; i++)
                    begin
                        r.val = (f == F_DUMP) ? shadow_list[i] : shadow_list[n - 1 - i];
                        r.lst = (i == n - 1);
                        r.cnt = n[CNT_W-1:0];
                        pending_results.push_back(r);
                    end
                    return;
                end
            end
        endcase
        r.cnt = CNT_W'(shadow_list.size());
        pending_results.push_back(r);
    endfunction

    // Send one item after a random gap and predict its results on acceptance.
    task automatic send_op(func_t f, logic signed [DATA_W-1:0] v, logic [POS_W-1:0] p);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        func <= f;
        value_in <= v;
        position <= p;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predict_list_op(f, v, p);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (CAP + 8) @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] random_value();
        case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Every operation but a rear insert on the empty list, then the rejects and the field extremes.
    task automatic test_empty_and_rejects();
        send_op(F_DEL_FRONT, '0, '0);
        send_op(F_DEL_REAR, '0, '0);
        send_op(F_DEL_AT, '0, '0);
        send_op(F_DUMP, '0, '0);
        send_op(F_DUMP_REV, '0, '0);
        send_op(F_INS_AT, 32'sd5, 6'd1);
        send_op(F_INS_AT, 32'sd5, 6'd63);
        send_op(F_INS_FRONT, 32'sh8000_0000, 6'd63);
        send_op(F_INS_REAR, 32'sh7FFF_FFFF, '0);
        send_op(F_INS_AT, -32'sd1, 6'd1);
        send_op(F_INS_AT, 32'sd0, 6'd3);
        send_op(F_DEL_AT, '0, 6'd3);
        send_op(F_DUMP, '0, '0);
        send_op(F_DUMP_REV, '0, '0);
        send_op(F_DEL_AT, '1, 6'd1);
        send_op(F_DEL_REAR, '0, '0);
        send_op(F_DEL_FRONT, '0, '0);
        drain_results();
    endtask

    // Fill to capacity, try an overflow and a bad position, dump, then empty out.
    task automatic test_full_list();
        while (shadow_list.size() < CAP)
            send_op(func_t'($urandom_range(F_INS_FRONT, F_INS_AT)), random_value(),
                    POS_W'($urandom_range(0, shadow_list.size())));
        send_op(F_INS_FRONT, 32'sd1, '0);
        send_op(F_INS_AT, 32'sd1, 6'd32);
        send_op(F_INS_AT, 32'sd1, 6'd33);
        send_op(F_DUMP, '0, '0);
        send_op(F_DUMP_REV, '0, '0);
        send_op(F_DEL_AT, '0, 6'd31);
        send_op(F_DEL_AT, '0, 6'd32);
        while (shadow_list.size() > 0)
            send_op(func_t'($urandom_range(F_DEL_FRONT, F_DEL_AT)), '0,
                    POS_W'($urandom_range(0, shadow_list.size() - 1)));
        drain_results();
    endtask

    // Random mix: mostly valid positions, some bad ones, the occasional dump.
    task automatic test_random_ops();
        func_t f;
        int    pick;
        int    p;
        for (int k = 0; k < 90; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                f = func_t'($urandom_range(F_INS_FRONT, F_INS_AT));
            else if (pick < 88)
                f = func_t'($urandom_range(F_DEL_FRONT, F_DEL_AT));
            else
                f = func_t'($urandom_range(F_DUMP, F_DUMP_REV));
            // Bias toward growth in the first half so the list gets near full.
            if (k < 45 && pick >= 50 && pick < 70)
                f = F_INS_REAR;
            if ($urandom_range(0, 9) == 0)
                p = $urandom_range(0, 63);
            else
                p = $urandom_range(0, shadow_list.size());
            send_op(f, random_value(), p[POS_W-1:0]);
        end
        drain_results();
    endtask

    // Stall the result side at random after each taken result.
    always @(negedge clk)
    begin
        if (out_taken)
            wait_left = $urandom_range(0, 9);
        if (wait_left > 0)
        begin
            out_stall <= 1'b1;
            wait_left--;
        end
        else
            out_stall <= 1'b0;
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        out_taken <= rst_n && out_valid && !out_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d value %0d", status, value_out);
                error_count++;
            end
            else
            begin
                list_result_t e;
                e = pending_results.pop_front();
                if (status !== e.st)
                begin
                    $error("status: expected %0d, got %0d", e.st, status);
                    error_count++;
                end
                if (value_out !== e.val)
                begin
                    $error("value_out: expected %0d, got %0d", e.val, value_out);
                    error_count++;
                end
                if (last !== e.lst)
                begin
                    $error("last: expected %0d, got %0d", e.lst, last);
                    error_count++;
                end
                if (count !== e.cnt)
                begin
                    $error("count: expected %0d, got %0d", e.cnt, count);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_empty_and_rejects();
        test_full_list();
        test_random_ops();
        if (error_count == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
